// ----- src/distinct_value_histogram_unit_defines.svh -----
// assertion macros for the histogram unit
`ifndef DISTINCT_VALUE_HISTOGRAM_UNIT_DEFINES_SVH
`define DISTINCT_VALUE_HISTOGRAM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DVH_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dvh: forbidden condition");
`define DVH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvh: expected follow-up missing");
`else
`define DVH_ASSERT_NEVER(lbl, cond)
`define DVH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/dvh_pkg.sv -----
package dvh_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int MAX_WINDOW_DEF  = 15;
    localparam int SAMPLE_IN_W     = 16;
    localparam int COUNT_OUT_W     = 24;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 4;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } dvh_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTH_WINDOW   = 2'd0,
        REG_CUMULATIVE_MODE = 2'd1
    } dvh_reg_t;

    typedef struct packed {
        dvh_mode_t              kind;
        logic [SAMPLE_IN_W-1:0] sample;
    } dvh_cmd_t;

    typedef struct packed {
        logic clearing;
        logic active;
        logic out_load;
    } dvh_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD_WR,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_AFTER,
        B_SUM,
        B_CUM,
        B_EMIT
    } dvh_state_t;

endpackage

// ----- src/dvh_ram.sv -----
module dvh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/dvh_front.sv -----
module dvh_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_mode,
    input  logic [dvh_pkg::SAMPLE_IN_W-1:0]   in_sample,
    input  logic                              clearing,
    output dvh_pkg::dvh_cmd_t                 cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_pop
);
    import dvh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    dvh_cmd_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W:0]     count_reg;
    logic               push;
    logic               pop;
    logic               known;

    // unused mode code is dropped here
    assign known    = (in_mode == MODE_LOAD) || (in_mode == MODE_READ)
                   || (in_mode == MODE_CLEAR);
    assign in_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH)) && !clearing;
    assign push     = in_valid && in_ready && known;
    assign cmd_valid = (count_reg != '0);
    assign pop      = cmd_pop && cmd_valid;
    assign cmd      = queue_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[tail_reg] <= '{kind: dvh_mode_t'(in_mode), sample: in_sample};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/dvh_back.sv -----
module dvh_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int MAX_WINDOW  = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dvh_pkg::dvh_cmd_t                 cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  logic [dvh_pkg::CFG_DATA_W-1:0]    smooth_window,
    input  logic                              cumulative_mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dvh_pkg::SAMPLE_IN_W-1:0]   out_value,
    output logic [dvh_pkg::COUNT_OUT_W-1:0]   out_count,
    output logic                              out_last,
    output dvh_pkg::dvh_status_t              status
);
    import dvh_pkg::*;

    localparam int NUM_BINS  = 1 << SAMPLE_BITS;
    localparam int WIN_DEPTH = MAX_WINDOW + 1;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    dvh_state_t                 state_reg;
    dvh_state_t                 state_next;
    logic [SAMPLE_BITS:0]       scan_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          target_reg;
    logic [COUNT_BITS-1:0]      win_cnt_reg [WIN_DEPTH];
    logic [SAMPLE_BITS-1:0]     win_val_reg [WIN_DEPTH];
    logic [COUNT_BITS-1:0]      total_reg;
    logic [COUNT_BITS-1:0]      count_reg;
    logic [SAMPLE_BITS-1:0]     value_reg;
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [IDX_W-1:0]           j_reg;
    logic                       post_reg;
    logic                       last_reg;
    logic                       active_reg;
    logic                       clear_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_IN_W-1:0]     out_value_reg;
    logic [COUNT_OUT_W-1:0]     out_count_reg;
    logic                       out_last_reg;

    logic                       ram_we;
    logic [SAMPLE_BITS-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0]      ram_wdata;
    logic [SAMPLE_BITS-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0]      ram_rdata;

    logic [6:0]                 sw_ext;
    logic [IDX_W-1:0]           win_w;
    logic [FILL_W-1:0]          win_need;
    logic [SAMPLE_BITS-1:0]     scan_addr;
    logic [SAMPLE_BITS-1:0]     cmd_addr;
    logic                       scan_stop;
    logic                       do_sum;
    logic                       out_load;
    logic [COUNT_BITS-1:0]      cum_sum;

    assign sw_ext    = 7'(smooth_window);
    assign win_w     = (sw_ext > 7'(MAX_WINDOW)) ? IDX_W'(MAX_WINDOW) : IDX_W'(sw_ext);
    assign win_need  = FILL_W'(win_w) + 1'b1;
    assign scan_addr = scan_reg[SAMPLE_BITS-1:0];
    assign cmd_addr  = SAMPLE_BITS'(cmd.sample);
    assign scan_stop = (fill_reg >= target_reg) || scan_reg[SAMPLE_BITS];
    assign do_sum    = (win_w != '0) && (fill_reg >= win_need);
    assign out_load  = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
    assign cum_sum   = sat_add(total_reg, count_reg);

    dvh_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(NUM_BINS)
    ) u_bins (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && !clear_reg)
                begin
                    case (cmd.kind)
                        MODE_LOAD:  state_next = active_reg ? B_IDLE : B_LOAD_WR;
                        MODE_READ:  state_next = B_SCAN_RD;
                        MODE_CLEAR: state_next = B_IDLE;
                        default:    state_next = B_IDLE;
                    endcase
                end
            end
            B_LOAD_WR:  state_next = B_IDLE;
            B_SCAN_RD:  state_next = scan_stop ? B_AFTER : B_SCAN_CHK;
            B_SCAN_CHK: state_next = B_SCAN_RD;
            B_AFTER:
            begin
                if (post_reg)
                begin
                    state_next = B_EMIT;
                end
                else if (fill_reg == '0)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    state_next = do_sum ? B_SUM : B_CUM;
                end
            end
            B_SUM:      state_next = (j_reg == win_w) ? B_CUM : B_SUM;
            B_CUM:      state_next = B_SCAN_RD;
            B_EMIT:     state_next = out_load ? B_IDLE : B_EMIT;
            default:    state_next = B_IDLE;
        endcase
    end

    // memory and queue control
    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = scan_addr;
        ram_wdata = '0;
        ram_raddr = scan_addr;
        case (state_reg)
            B_IDLE:
            begin
                cmd_pop   = cmd_valid && !clear_reg;
                ram_raddr = cmd_addr;
                // reset and clear sweep zero one bin per cycle
                ram_we    = clear_reg;
            end
            B_LOAD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sample_reg;
                ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
            end
            B_SCAN_RD:
            begin
                // scanned bins are zeroed as they go
                ram_we = !scan_stop;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign status.clearing = clear_reg;
    assign status.active   = active_reg;
    assign status.out_load = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            active_reg    <= 1'b0;
            clear_reg     <= 1'b1;
            fill_reg      <= '0;
            scan_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (clear_reg)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        if (scan_addr == '1)
                        begin
                            clear_reg <= 1'b0;
                            scan_reg  <= '0;
                        end
                    end
                    else
                    begin
                        if (cmd_valid && (cmd.kind == MODE_READ) && !active_reg)
                        begin
                            active_reg <= 1'b1;
                            fill_reg   <= '0;
                            scan_reg   <= '0;
                            total_reg  <= '0;
                        end
                        if (cmd_valid && (cmd.kind == MODE_CLEAR))
                        begin
                            active_reg <= 1'b0;
                            clear_reg  <= 1'b1;
                            fill_reg   <= '0;
                            scan_reg   <= '0;
                            total_reg  <= '0;
                        end
                    end
                end
                B_SCAN_CHK:
                begin
                    if (ram_rdata != '0)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    scan_reg <= scan_reg + 1'b1;
                end
                B_AFTER:
                begin
                    if ((post_reg && (fill_reg == '0)) || (!post_reg && (fill_reg == '0)))
                    begin
                        if (!post_reg)
                        begin
                            active_reg <= 1'b0;
                            scan_reg   <= '0;
                            total_reg  <= '0;
                        end
                    end
                end
                B_CUM:
                begin
                    if (cumulative_mode)
                    begin
                        total_reg <= cum_sum;
                    end
                    fill_reg <= fill_reg - 1'b1;
                end
                B_EMIT:
                begin
                    if (out_load && last_reg)
                    begin
                        active_reg <= 1'b0;
                        fill_reg   <= '0;
                        scan_reg   <= '0;
                        total_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                sample_reg <= cmd_addr;
                target_reg <= win_need;
                post_reg   <= 1'b0;
            end
            B_SCAN_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    win_cnt_reg[fill_reg[IDX_W-1:0]] <= ram_rdata;
                    win_val_reg[fill_reg[IDX_W-1:0]] <= scan_addr;
                end
            end
            B_AFTER:
            begin
                last_reg <= (fill_reg == '0);
                // after the shift the finished count stays put
                if (!post_reg)
                begin
                    j_reg     <= '0;
                    count_reg <= do_sum ? '0 : win_cnt_reg[0];
                end
            end
            B_SUM:
            begin
                count_reg <= sat_add(count_reg, win_cnt_reg[j_reg]);
                j_reg     <= j_reg + 1'b1;
            end
            B_CUM:
            begin
                if (cumulative_mode)
                begin
                    count_reg <= cum_sum;
                end
                value_reg <= win_val_reg[0];
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_cnt_reg[i] <= win_cnt_reg[i+1];
                    win_val_reg[i] <= win_val_reg[i+1];
                end
                win_cnt_reg[WIN_DEPTH-1] <= '0;
                win_val_reg[WIN_DEPTH-1] <= '0;
                post_reg   <= 1'b1;
                target_reg <= FILL_W'(1);
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    out_value_reg <= SAMPLE_IN_W'(value_reg);
                    out_count_reg <= COUNT_OUT_W'(count_reg);
                    out_last_reg  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- src/distinct_value_histogram_unit.sv -----
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+-------------------------------------
// s_        | in  | s_tvalid / s_tready        | s_tdata: sample; s_tuser: mode
// m_        | out | m_tvalid / m_tready        | m_tdata: bin_value, bin_count; m_tlast
// cfg_      | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// a load is a read-modify-write on the single bin memory
// a read walks the bins with the scan (B_SCAN_RD, then B_SCAN_CHK per bin), sums up
// to window+1 window entries and then does its bookkeeping; a full walk visits every bin
// a clear request starts a sweep over all 2^SAMPLE_BITS bins, one bin per cycle
// after rst_n the same sweep zeroes the bins; s_tready stays low
// while a sweep runs; a result waits in the output register while the front queue
// keeps taking up to 4 requests
module distinct_value_histogram_unit #(
    parameter int SAMPLE_BITS = dvh_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = dvh_pkg::COUNT_BITS_DEF,
    parameter int MAX_WINDOW  = dvh_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] sample
    input  logic [1:0]                         s_tuser,   // [1:0] mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,   // [15:0] bin_value, [39:16] bin_count
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dvh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dvh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dvh_pkg::*;

`include "distinct_value_histogram_unit_defines.svh"

    dvh_cmd_t                 cmd;
    logic                     cmd_valid;
    logic                     cmd_pop;
    dvh_status_t              status;
    logic [CFG_DATA_W-1:0]    smooth_window_reg;
    logic                     cumulative_mode_reg;
    logic [SAMPLE_IN_W-1:0]   out_value;
    logic [COUNT_OUT_W-1:0]   out_count;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_window_reg   <= '0;
            cumulative_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SMOOTH_WINDOW:   smooth_window_reg   <= cfg_data;
                REG_CUMULATIVE_MODE: cumulative_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // front: takes requests, drops unused modes, buffers the rest
    dvh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_sample(s_tdata),
        .clearing (status.clearing),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop)
    );

    // back: bin memory, scan, window and output register
    dvh_back #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .smooth_window  (smooth_window_reg),
        .cumulative_mode(cumulative_mode_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_value      (out_value),
        .out_count      (out_count),
        .out_last       (m_tlast),
        .status         (status)
    );

    assign m_tdata = {out_count, out_value};

    `DVH_ASSERT_NEXT(a_load_shows, status.out_load, m_tvalid)
    `DVH_ASSERT_NEVER(a_load_while_full, status.out_load && m_tvalid && !m_tready)

endmodule
